### rtl/lsic_pkg.sv
// Shared types, widths and class codes for the line/segment classifier.
// No dependencies; every rtl file imports this package.
package lsic_pkg;

	localparam int CW = 32;          // coordinate width, Q16.16
	localparam int DW = CW + 1;      // coordinate difference
	localparam int PW = 2 * DW;      // product of two differences
	localparam int XW = PW + 1;      // cross product
	localparam int NW = 3 * DW;      // |num| * |u| before division
	localparam int QB = CW + 2;      // quotient bits resolved by the divider
	localparam int RW = PW + 1;      // partial remainder

	localparam logic [2:0] CLS_CROSS       = 3'd0;
	localparam logic [2:0] CLS_LEFT        = 3'd1;
	localparam logic [2:0] CLS_RIGHT       = 3'd2;
	localparam logic [2:0] CLS_COLLINEAR   = 3'd3;
	localparam logic [2:0] CLS_DEGENERATE  = 3'd4;
	localparam logic [2:0] CLS_TOUCH_LEFT  = 3'd5;
	localparam logic [2:0] CLS_TOUCH_RIGHT = 3'd6;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_coord;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
	} query_t;

	typedef struct packed {
		logic [2:0]           class_code;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
	} result_t;

	// per-transaction control carried alongside the divider
	typedef struct packed {
		logic [2:0]           code;
		logic                 is_cross;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] px;   // a for a crossing, else the final point
		logic signed [CW-1:0] py;
	} ctl_t;

	// one divider lane: remainder plus shared dividend-low / quotient register
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QB-1:0] lq;
		logic          ovf;
	} lane_t;

	// cross products leaving the front end
	typedef struct packed {
		logic signed [XW-1:0] oc;
		logic signed [XW-1:0] od;
		logic signed [XW-1:0] den;
		logic signed [XW-1:0] num;
		logic signed [DW-1:0] ux;
		logic signed [DW-1:0] uy;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
	} xprod_t;

endpackage

### rtl/lsic_front.sv
// Front end: differences, eight products, cross products (three stages).
// Depends on lsic_pkg.
module lsic_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  lsic_pkg::query_t q,
	output logic            out_vld,
	output lsic_pkg::xprod_t xp
);
	import lsic_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0] ux_s1, uy_s1, cax_s1, cay_s1, dax_s1, day_s1, dcx_s1, dcy_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	logic signed [PW-1:0] oc1_s2, oc2_s2, od1_s2, od2_s2, dn1_s2, dn2_s2, nm1_s2, nm2_s2;
	logic signed [DW-1:0] ux_s2, uy_s2;
	logic signed [CW-1:0] ax_s2, ay_s2, cx_s2, cy_s2, dx_s2, dy_s2;
	xprod_t               xp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ux_s1  <= DW'(q.bx) - DW'(q.ax);
		uy_s1  <= DW'(q.by_coord) - DW'(q.ay);
		cax_s1 <= DW'(q.cx) - DW'(q.ax);
		cay_s1 <= DW'(q.cy) - DW'(q.ay);
		dax_s1 <= DW'(q.dx) - DW'(q.ax);
		day_s1 <= DW'(q.dy) - DW'(q.ay);
		dcx_s1 <= DW'(q.dx) - DW'(q.cx);
		dcy_s1 <= DW'(q.dy) - DW'(q.cy);
		ax_s1  <= q.ax;
		ay_s1  <= q.ay;
		cx_s1  <= q.cx;
		cy_s1  <= q.cy;
		dx_s1  <= q.dx;
		dy_s1  <= q.dy;

		oc1_s2 <= ux_s1 * cay_s1;
		oc2_s2 <= uy_s1 * cax_s1;
		od1_s2 <= ux_s1 * day_s1;
		od2_s2 <= uy_s1 * dax_s1;
		dn1_s2 <= dcx_s1 * uy_s1;
		dn2_s2 <= dcy_s1 * ux_s1;
		nm1_s2 <= dax_s1 * cay_s1;
		nm2_s2 <= day_s1 * cax_s1;
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;

		xp_s3.oc  <= XW'(oc1_s2) - XW'(oc2_s2);
		xp_s3.od  <= XW'(od1_s2) - XW'(od2_s2);
		xp_s3.den <= XW'(dn1_s2) - XW'(dn2_s2);
		xp_s3.num <= XW'(nm1_s2) - XW'(nm2_s2);
		xp_s3.ux  <= ux_s2;
		xp_s3.uy  <= uy_s2;
		xp_s3.ax  <= ax_s2;
		xp_s3.ay  <= ay_s2;
		xp_s3.cx  <= cx_s2;
		xp_s3.cy  <= cy_s2;
		xp_s3.dx  <= dx_s2;
		xp_s3.dy  <= dy_s2;
	end

	assign out_vld = vld_s3;
	assign xp      = xp_s3;

endmodule

### rtl/lsic_scale.sv
// Classification, then |num|*|u| as split partial products (two stages).
// Depends on lsic_pkg.
module lsic_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  lsic_pkg::xprod_t xp,
	output logic             out_vld,
	output lsic_pkg::ctl_t   ctl,
	output logic [lsic_pkg::PW-1:0] den_mag,
	output logic [lsic_pkg::NW-1:0] nx,
	output logic [lsic_pkg::NW-1:0] ny
);
	import lsic_pkg::*;

	logic          c_zero, d_zero, c_neg, d_neg, c_pos, d_pos, den_zero;
	logic [XW-1:0] num_abs, den_abs;
	logic [DW-1:0] ux_abs, uy_abs;
	ctl_t          ctl_d;

	logic          vld_s4, vld_s5;
	ctl_t          ctl_s4, ctl_s5;
	logic [PW-1:0] den_s4, den_s5;
	logic [PW-1:0] pxh_s4, pxl_s4, pyh_s4, pyl_s4;
	logic [NW-1:0] nx_s5, ny_s5;

	always_comb begin
		c_zero   = (xp.oc == '0);
		d_zero   = (xp.od == '0);
		c_neg    = xp.oc[XW-1];
		d_neg    = xp.od[XW-1];
		c_pos    = !c_zero && !c_neg;
		d_pos    = !d_zero && !d_neg;
		den_zero = (xp.den == '0);
		num_abs  = xp.num[XW-1] ? -xp.num : xp.num;
		den_abs  = xp.den[XW-1] ? -xp.den : xp.den;
		ux_abs   = xp.ux[DW-1] ? -xp.ux : xp.ux;
		uy_abs   = xp.uy[DW-1] ? -xp.uy : xp.uy;

		ctl_d.is_cross = 1'b0;
		ctl_d.neg_x = xp.num[XW-1] ^ xp.ux[DW-1] ^ xp.den[XW-1];
		ctl_d.neg_y = xp.num[XW-1] ^ xp.uy[DW-1] ^ xp.den[XW-1];
		ctl_d.px    = '0;
		ctl_d.py    = '0;
		priority if (c_zero && d_zero) begin
			ctl_d.code = CLS_COLLINEAR;
		end else if (c_pos && d_pos) begin
			ctl_d.code = CLS_LEFT;
		end else if (c_neg && d_neg) begin
			ctl_d.code = CLS_RIGHT;
		end else if (c_zero) begin
			ctl_d.code = d_pos ? CLS_TOUCH_LEFT : CLS_TOUCH_RIGHT;
			ctl_d.px   = xp.cx;
			ctl_d.py   = xp.cy;
		end else if (d_zero) begin
			ctl_d.code = c_pos ? CLS_TOUCH_LEFT : CLS_TOUCH_RIGHT;
			ctl_d.px   = xp.dx;
			ctl_d.py   = xp.dy;
		end else if (den_zero) begin
			ctl_d.code = CLS_DEGENERATE;
		end else begin
			ctl_d.code     = CLS_CROSS;
			ctl_d.is_cross = 1'b1;
			ctl_d.px       = xp.ax;
			ctl_d.py       = xp.ay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= in_vld;
			vld_s5 <= vld_s4;
		end
	end

	// |num| fits PW bits; split into two DW-bit halves
	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_d;
		den_s4 <= den_abs[PW-1:0];
		pxh_s4 <= num_abs[PW-1:DW] * ux_abs;
		pxl_s4 <= num_abs[DW-1:0]  * ux_abs;
		pyh_s4 <= num_abs[PW-1:DW] * uy_abs;
		pyl_s4 <= num_abs[DW-1:0]  * uy_abs;

		ctl_s5 <= ctl_s4;
		den_s5 <= den_s4;
		nx_s5  <= {pxh_s4, {DW{1'b0}}} + NW'(pxl_s4);
		ny_s5  <= {pyh_s4, {DW{1'b0}}} + NW'(pyl_s4);
	end

	assign out_vld = vld_s5;
	assign ctl     = ctl_s5;
	assign den_mag = den_s5;
	assign nx      = nx_s5;
	assign ny      = ny_s5;

endmodule

### rtl/lsic_div_step.sv
// One restoring-division step for the x and y lanes, registered.
// Depends on lsic_pkg.
module lsic_div_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  lsic_pkg::ctl_t   in_ctl,
	input  logic [lsic_pkg::PW-1:0] in_den,
	input  lsic_pkg::lane_t  in_x,
	input  lsic_pkg::lane_t  in_y,
	output logic             out_vld,
	output lsic_pkg::ctl_t   out_ctl,
	output logic [lsic_pkg::PW-1:0] out_den,
	output lsic_pkg::lane_t  out_x,
	output lsic_pkg::lane_t  out_y
);
	import lsic_pkg::*;

	logic [RW-1:0] tx, ty;
	logic          gx, gy;
	lane_t         nxt_x, nxt_y;
	logic          vld_q;
	ctl_t          ctl_q;
	logic [PW-1:0] den_q;
	lane_t         x_q, y_q;

	always_comb begin
		tx = {in_x.rem[RW-2:0], in_x.lq[QB-1]};
		ty = {in_y.rem[RW-2:0], in_y.lq[QB-1]};
		gx = (tx >= {1'b0, in_den});
		gy = (ty >= {1'b0, in_den});
		nxt_x.rem = gx ? tx - {1'b0, in_den} : tx;
		nxt_y.rem = gy ? ty - {1'b0, in_den} : ty;
		nxt_x.lq  = {in_x.lq[QB-2:0], gx};
		nxt_y.lq  = {in_y.lq[QB-2:0], gy};
		nxt_x.ovf = in_x.ovf;
		nxt_y.ovf = in_y.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q <= in_ctl;
		den_q <= in_den;
		x_q   <= nxt_x;
		y_q   <= nxt_y;
	end

	assign out_vld = vld_q;
	assign out_ctl = ctl_q;
	assign out_den = den_q;
	assign out_x   = x_q;
	assign out_y   = y_q;

endmodule

### rtl/line_segment_intersect_classify_core.sv
// Top level: front end, classifier/scaler, divider chain, saturating output.
// Depends on lsic_pkg, lsic_front, lsic_scale, lsic_div_step.
// Path to done: front end, scaler, divider set-up, one divider stage per quotient bit,
// then the output register. Throughput: one transaction per cycle.
// busy is always low; results cannot be held off and appear as a one-cycle done strobe.
// arst_n clears every valid bit; payload registers are not reset.
module line_segment_intersect_classify_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lsic_pkg::query_t  query,
	output logic              done,
	output lsic_pkg::result_t result
);
	import lsic_pkg::*;

	logic          fr_vld, sc_vld;
	xprod_t        fr_xp;
	ctl_t          sc_ctl;
	logic [PW-1:0] sc_den;
	logic [NW-1:0] sc_nx, sc_ny;

	logic          vld_s6;
	ctl_t          ctl_s6;
	logic [PW-1:0] den_s6;
	lane_t         x_s6, y_s6;

	logic          dv_vld [QB+1];
	ctl_t          dv_ctl [QB+1];
	logic [PW-1:0] dv_den [QB+1];
	lane_t         dv_x   [QB+1];
	lane_t         dv_y   [QB+1];

	ctl_t                 fc;
	lane_t                fx, fy;
	logic signed [QB+1:0] sum_x, sum_y;
	logic signed [CW-1:0] sat_x, sat_y;
	logic                 done_q;
	result_t              res_q;

	assign busy = 1'b0;

	lsic_front u_front (
		.clk, .arst_n,
		.in_vld (start),
		.q      (query),
		.out_vld(fr_vld),
		.xp     (fr_xp)
	);

	lsic_scale u_scale (
		.clk, .arst_n,
		.in_vld (fr_vld),
		.xp     (fr_xp),
		.out_vld(sc_vld),
		.ctl    (sc_ctl),
		.den_mag(sc_den),
		.nx     (sc_nx),
		.ny     (sc_ny)
	);

	// divider set-up: a quotient wider than QB bits is flagged as overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= sc_vld;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s6   <= sc_ctl;
		den_s6   <= sc_den;
		x_s6.rem <= RW'(sc_nx[NW-1:QB]);
		y_s6.rem <= RW'(sc_ny[NW-1:QB]);
		x_s6.lq  <= sc_nx[QB-1:0];
		y_s6.lq  <= sc_ny[QB-1:0];
		x_s6.ovf <= (PW'(sc_nx[NW-1:QB]) >= sc_den);
		y_s6.ovf <= (PW'(sc_ny[NW-1:QB]) >= sc_den);
	end

	assign dv_vld[0] = vld_s6;
	assign dv_ctl[0] = ctl_s6;
	assign dv_den[0] = den_s6;
	assign dv_x[0]   = x_s6;
	assign dv_y[0]   = y_s6;

	for (genvar i = 0; i < QB; i++) begin : g_div
		lsic_div_step u_step (
			.clk, .arst_n,
			.in_vld (dv_vld[i]),
			.in_ctl (dv_ctl[i]),
			.in_den (dv_den[i]),
			.in_x   (dv_x[i]),
			.in_y   (dv_y[i]),
			.out_vld(dv_vld[i+1]),
			.out_ctl(dv_ctl[i+1]),
			.out_den(dv_den[i+1]),
			.out_x  (dv_x[i+1]),
			.out_y  (dv_y[i+1])
		);
	end

	// a + signed quotient, then clamp to the coordinate range
	always_comb begin
		fc    = dv_ctl[QB];
		fx    = dv_x[QB];
		fy    = dv_y[QB];
		sum_x = (QB+2)'(fc.px) + (fc.neg_x ? -(QB+2)'(fx.lq) : (QB+2)'(fx.lq));
		sum_y = (QB+2)'(fc.py) + (fc.neg_y ? -(QB+2)'(fy.lq) : (QB+2)'(fy.lq));

		if (fx.ovf || (sum_x[QB+1:CW-1] != {(QB-CW+3){sum_x[QB+1]}})) begin
			sat_x = (fx.ovf ? fc.neg_x : sum_x[QB+1]) ?
				{1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat_x = sum_x[CW-1:0];
		end
		if (fy.ovf || (sum_y[QB+1:CW-1] != {(QB-CW+3){sum_y[QB+1]}})) begin
			sat_y = (fy.ovf ? fc.neg_y : sum_y[QB+1]) ?
				{1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			sat_y = sum_y[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[QB];
		end
	end

	always_ff @(posedge clk) begin
		res_q.class_code <= fc.code;
		res_q.px         <= fc.is_cross ? sat_x : fc.px;
		res_q.py         <= fc.is_cross ? sat_y : fc.py;
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef ASSERT_OFF
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.class_code != 3'd7))
		else $error("class code out of range");

	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.class_code == CLS_LEFT || result.class_code == CLS_RIGHT ||
		         result.class_code == CLS_COLLINEAR ||
		         result.class_code == CLS_DEGENERATE)
		|-> (result.px == '0 && result.py == '0))
		else $error("point not cleared for a non-meeting class");

	a_div_cross: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[QB] && fc.is_cross |-> (dv_den[QB] != '0))
		else $error("crossing with zero denominator");
`endif

endmodule
